@@ design/life_grid_generation_step_defines.svh @@
// assertion macros used by the checker in lgs_checker.sv
`ifndef LIFE_GRID_GENERATION_STEP_DEFINES_SVH
`define LIFE_GRID_GENERATION_STEP_DEFINES_SVH

// same-cycle implication, sampled on clock and disabled in reset
`define LGS_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lgs same-cycle check failed");

// next-cycle implication, sampled on clock and disabled in reset
`define LGS_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lgs next-cycle check failed");

`endif

@@ design/lgs_pkg.sv @@
package lgs_pkg;

   // command codes
   localparam logic [2:0] FUNC_STEP  = 3'd0;
   localparam logic [2:0] FUNC_WRITE = 3'd1;
   localparam logic [2:0] FUNC_CLEAR = 3'd2;
   localparam logic [2:0] FUNC_PAUSE = 3'd3;
   localparam logic [2:0] FUNC_READ  = 3'd4;

   // request item
   typedef struct packed {
      logic [2:0] func;
      logic [6:0] col;
      logic [6:0] row;
      logic       alive;
   } req_payload_type;

   // response item
   typedef struct packed {
      logic        cell_value;
      logic [31:0] generation_count;
      logic        is_paused;
   } rsp_payload_type;

   // controller to datapath commands
   typedef struct packed {
      logic load_item;
      logic rd_item;
      logic wr_item;
      logic sweep_init;
      logic sweep_step;
      logic clear_grid;
      logic toggle_pause;
      logic gen_inc;
      logic load_rsp;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic [2:0] func;
      logic       paused;
      logic       sweep_last;
   } status_type;

endpackage

@@ design/lgs_stream_if.sv @@
interface lgs_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ design/lgs_ctrl.sv @@
module lgs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  lgs_pkg::status_type status,
   output lgs_pkg::cmd_type    cmd
);
   import lgs_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_MODIFY = 3'd2;
   localparam logic [2:0] S_SWEEP  = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_EXEC;
            end
         end
         S_EXEC: begin
            case (status.func)
               FUNC_STEP: begin
                  if (status.paused) begin
                     state_in = S_DONE;
                  end else begin
                     cmd.sweep_init = 1'b1;
                     state_in       = S_SWEEP;
                  end
               end
               FUNC_WRITE: begin
                  cmd.rd_item = 1'b1;
                  state_in    = S_MODIFY;
               end
               FUNC_CLEAR: begin
                  cmd.clear_grid = 1'b1;
                  state_in       = S_DONE;
               end
               FUNC_PAUSE: begin
                  cmd.toggle_pause = 1'b1;
                  state_in         = S_DONE;
               end
               FUNC_READ: begin
                  cmd.rd_item = 1'b1;
                  state_in    = S_DONE;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_MODIFY: begin
            cmd.wr_item = 1'b1;
            state_in    = S_DONE;
         end
         S_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (status.sweep_last) begin
               cmd.gen_inc = 1'b1;
               state_in    = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // response valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

@@ design/lgs_datapath.sv @@
module lgs_datapath #(
   parameter int GRID_COLS = 128,
   parameter int GRID_ROWS = 128
) (
   input  logic                     clock,
   input  logic                     reset,
   input  lgs_pkg::req_payload_type req_payload,
   input  lgs_pkg::cmd_type         cmd,
   output lgs_pkg::status_type      status,
   output lgs_pkg::rsp_payload_type rsp_payload
);
   import lgs_pkg::*;

   localparam int RowAw  = $clog2(GRID_ROWS);
   localparam int ColAw  = $clog2(GRID_COLS);
   localparam int SweepW = $clog2(GRID_ROWS + 2);
   localparam logic [SweepW-1:0] SweepRows = SweepW'(GRID_ROWS);
   localparam logic [SweepW-1:0] SweepLast = SweepW'(GRID_ROWS + 1);
   localparam logic [SweepW-1:0] SweepTwo  = SweepW'(2);
   localparam logic [SweepW-1:0] SweepOne  = SweepW'(1);

   // row memory, one row of cells per entry
   logic [GRID_COLS-1:0] grid_ff [GRID_ROWS];
   logic [GRID_ROWS-1:0] row_valid_ff;
   logic [GRID_COLS-1:0] rd_data_ff;
   logic                 rd_ok_ff;

   // line buffers for the sweep
   logic [GRID_COLS-1:0] prev_ff, cur_ff;
   logic [SweepW-1:0]    sweep_ff, sweep_in;

   req_payload_type      item_ff;
   logic [31:0]          gen_ff, gen_in;
   logic                 paused_ff;
   rsp_payload_type      rsp_ff;

   logic                 item_inside;
   logic [RowAw-1:0]     item_row_idx;
   logic [ColAw-1:0]     item_col_idx;
   logic [GRID_COLS-1:0] row_q, cell_row, life_row, wr_data;
   logic [SweepW-1:0]    wr_sweep;
   logic                 sweep_rd, sweep_shift, sweep_wr;
   logic                 rd_en, wr_en;
   logic [RowAw-1:0]     rd_addr, wr_addr;

   // item position decode
   assign item_inside  = (32'(item_ff.row) < GRID_ROWS) && (32'(item_ff.col) < GRID_COLS);
   assign item_row_idx = RowAw'(item_ff.row);
   assign item_col_idx = ColAw'(item_ff.col);

   // rows never written since reset or clear read as dead
   assign row_q = rd_ok_ff ? rd_data_ff : '0;

   // sweep phase: read row k, write row k-2
   assign sweep_rd    = (sweep_ff < SweepRows);
   assign sweep_shift = (sweep_ff >= SweepOne);
   assign sweep_wr    = (sweep_ff >= SweepTwo);
   assign wr_sweep    = sweep_ff - SweepTwo;

   assign rd_en   = (cmd.rd_item && item_inside) || (cmd.sweep_step && sweep_rd);
   assign rd_addr = cmd.rd_item ? item_row_idx : sweep_ff[RowAw-1:0];
   assign wr_en   = (cmd.wr_item && item_inside) || (cmd.sweep_step && sweep_wr);
   assign wr_addr = cmd.wr_item ? item_row_idx : wr_sweep[RowAw-1:0];
   assign wr_data = cmd.wr_item ? cell_row : life_row;

   // single cell update of the fetched row
   always_comb begin
      cell_row = row_q;
      cell_row[item_col_idx] = item_ff.alive;
   end

   // b3/s23 rule for every column of the middle line, dead beyond the edges
   always_comb begin
      logic [GRID_COLS+1:0] up_p, mid_p, dn_p;
      logic [3:0]           cnt;
      up_p  = {1'b0, prev_ff, 1'b0};
      mid_p = {1'b0, cur_ff, 1'b0};
      dn_p  = {1'b0, row_q, 1'b0};
      for (int c = 0; c < GRID_COLS; c++) begin
         cnt = 4'(up_p[c]) + 4'(up_p[c+1]) + 4'(up_p[c+2])
             + 4'(mid_p[c]) + 4'(mid_p[c+2])
             + 4'(dn_p[c]) + 4'(dn_p[c+1]) + 4'(dn_p[c+2]);
         life_row[c] = (cnt == 4'd3) || (mid_p[c+1] && (cnt == 4'd2));
      end
   end

   // memory ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         grid_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= grid_ff[rd_addr];
      end
   end

   // row valid bits and read qualifier
   always_ff @(posedge clock) begin
      if (reset || cmd.clear_grid) begin
         row_valid_ff <= '0;
      end else if (wr_en) begin
         row_valid_ff[wr_addr] <= 1'b1;
      end
      if (reset) begin
         rd_ok_ff <= 1'b0;
      end else if (rd_en) begin
         rd_ok_ff <= row_valid_ff[rd_addr];
      end else if (cmd.sweep_step) begin
         rd_ok_ff <= 1'b0;
      end
   end

   // sweep counter and line buffers
   always_comb begin
      sweep_in = sweep_ff;
      if (cmd.sweep_init) begin
         sweep_in = '0;
      end else if (cmd.sweep_step) begin
         sweep_in = sweep_ff + SweepOne;
      end
   end

   always_ff @(posedge clock) begin
      sweep_ff <= sweep_in;
      if (cmd.sweep_init) begin
         prev_ff <= '0;
         cur_ff  <= '0;
      end else if (cmd.sweep_step && sweep_shift) begin
         prev_ff <= cur_ff;
         cur_ff  <= row_q;
      end
   end

   // generation counter and pause flag
   always_comb begin
      gen_in = gen_ff;
      if (cmd.clear_grid) begin
         gen_in = '0;
      end else if (cmd.gen_inc) begin
         gen_in = gen_ff + 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff    <= '0;
         paused_ff <= 1'b1;
      end else begin
         gen_ff <= gen_in;
         if (cmd.toggle_pause) begin
            paused_ff <= ~paused_ff;
         end
      end
   end

   // item and response registers
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_ff <= req_payload;
      end
      if (cmd.load_rsp) begin
         rsp_ff.cell_value       <= (item_ff.func == FUNC_READ) && item_inside && rd_ok_ff
                                    && rd_data_ff[item_col_idx];
         rsp_ff.generation_count <= gen_ff;
         rsp_ff.is_paused        <= paused_ff;
      end
   end

   assign status.func       = item_ff.func;
   assign status.paused     = paused_ff;
   assign status.sweep_last = (sweep_ff == SweepLast);
   assign rsp_payload       = rsp_ff;
endmodule

@@ design/life_grid_generation_step.sv @@
// Game of life (B3/S23) engine on a bounded grid, dead cells beyond the edges.
// req_chan carries one command per transfer: step a generation, write a cell,
// clear the grid, toggle pause or read a cell. rsp_chan returns one item per
// command with the read cell value, the generation count and the pause flag.
// A step sweeps through the row memory, reading one row per cycle and writing
// each new row back two rows behind, with two line buffers holding the rows above.
// One command is worked on at a time; the next request is taken once the
// response of the current one sits in the output register.
// A stalled response holds its payload; the block then finishes the command in
// flight and waits before loading the next response.
// Reset clears the grid (row valid bits), zeroes the counter and sets pause;
// it is usable in the cycle after reset drops.
module life_grid_generation_step #(
   parameter int GRID_COLS = 128,
   parameter int GRID_ROWS = 128
) (
   input logic         clock,
   input logic         reset,
   lgs_stream_if.sink   req_chan,
   lgs_stream_if.source rsp_chan
);
   import lgs_pkg::*;

   cmd_type         cmd;
   status_type      status;
   req_payload_type req_payload;
   rsp_payload_type rsp_payload;
   logic            req_ready;
   logic            rsp_valid;

   assign req_payload      = req_chan.payload;
   assign req_chan.ready   = req_ready;
   assign rsp_chan.valid   = rsp_valid;
   assign rsp_chan.payload = rsp_payload;

   // command sequencing
   lgs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // grid memory, sweep and counters
   lgs_datapath #(
      .GRID_COLS (GRID_COLS),
      .GRID_ROWS (GRID_ROWS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );
endmodule

@@ design/lgs_checker.sv @@
`include "life_grid_generation_step_defines.svh"

module lgs_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input lgs_pkg::rsp_payload_type rsp_payload
);
   import lgs_pkg::*;

   logic [1:0] pend_ff, pend_in;

   // commands taken but not yet answered
   always_comb begin
      pend_in = pend_ff;
      if (req_valid && req_ready) begin
         pend_in = pend_in + 2'd1;
      end
      if (rsp_valid && rsp_ready) begin
         pend_in = pend_in - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   `LGS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   `LGS_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_payload))
   `LGS_ASSERT_IMP(a_rsp_has_req, rsp_valid, pend_ff != 2'd0)
   `LGS_ASSERT_IMP(a_two_in_flight, pend_ff == 2'd2, !req_ready)
endmodule

bind life_grid_generation_step lgs_checker u_lgs_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);
